// ===== design/crs_pkg.sv =====
// Shared constants, types and index tables for the Cramer's rule solver.
`default_nettype none

package crs_pkg;

    localparam int MAX_SIZE   = 3;
    localparam int VALUE_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int IDX_W  = 2;                     // row / column / variable fields
    localparam int ADDR_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int DET_W  = 49;                    // main_determinant field
    localparam int SOL_W  = 64;                    // solution field
    localparam int MULA_W = 2 * VALUE_BITS;        // running product after two factors
    localparam int PROD_W = 3 * VALUE_BITS;        // product of three factors
    localparam int TERM_W = 3;                     // up to six Sarrus terms
    localparam int DCNT_W = $clog2(SOL_W + 1);     // divider step counter

    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_SIZE);
    localparam logic [IDX_W-1:0] COL_NONE  = IDX_W'(MAX_SIZE);

    typedef enum logic [1:0] {
        CMD_COEF  = 2'd0,
        CMD_RHS   = 2'd1,
        CMD_SOLVE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_SAVE,
        ST_DIV,
        ST_WAIT,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic             clr_acc;
        logic             load;
        logic             mul;
        logic             acc_en;
        logic             acc_sub;
        logic             save_det;
        logic             div_start;
        logic             emit;
        logic [IDX_W-1:0] elem_row;
        logic [IDX_W-1:0] elem_col;
        logic             use_rhs;
        logic [IDX_W-1:0] var_idx;
        logic             last;
    } ctl_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic acc_zero;
        logic div_done;
        logic out_free;
    } st_t;

    // Column of factor j (row j) in term t of the determinant.
    function automatic logic [IDX_W-1:0] term_col(input logic size3,
                                                   input logic [TERM_W-1:0] t,
                                                   input logic [IDX_W-1:0] j);
        logic [TERM_W:0] c;
        c = '0;
        if (size3) begin
            if (t < TERM_W'(3)) begin
                c = {1'b0, t} + (TERM_W+1)'(j);
            end
            else begin
                c = {1'b0, t} - (TERM_W+1)'(j);   // (t-3) + 3 - j
            end
            if (c >= (TERM_W+1)'(3)) begin
                c = c - (TERM_W+1)'(3);
            end
        end
        else begin
            c = (t == '0) ? (TERM_W+1)'(j) : ((TERM_W+1)'(1) - (TERM_W+1)'(j));
        end
        return c[IDX_W-1:0];
    endfunction

    function automatic logic term_sub(input logic size3, input logic [TERM_W-1:0] t);
        return size3 ? (t >= TERM_W'(3)) : (t == TERM_W'(1));
    endfunction

endpackage

`default_nettype wire

// ===== design/crs_if.sv =====
// Item channel interfaces for solver requests and results.
`default_nettype none

interface crs_req_if;
    import crs_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [IDX_W-1:0]              row;
    logic [IDX_W-1:0]              column;
    logic signed [VALUE_BITS-1:0]  value;

    modport source (output valid, command, row, column, value, input ready);
    modport sink   (input valid, command, row, column, value, output ready);
endinterface

interface crs_res_if;
    import crs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         variable_index;
    logic signed [SOL_W-1:0]  solution;
    logic signed [DET_W-1:0]  main_determinant;
    logic                     singular;
    logic                     last;

    modport source (output valid, variable_index, solution, main_determinant, singular, last,
                    input ready);
    modport sink   (input valid, variable_index, solution, main_determinant, singular, last,
                    output ready);
endinterface

`default_nettype wire

// ===== design/cramer_rule_solver.sv =====
// Cramer's rule solver top level: 2x2 / 3x3 integer systems, fixed-point results.
// Write items (coefficient / right-hand side) are stored as accepted; the next item follows at once.
// Solve, size 3 or 2: the main determinant first, then for each unknown the column-replaced
// determinant, the bit-serial divider and the emit. A singular system emits each unknown
// without dividing. A stalled result channel holds the sequencer.
// Reset (async, active low) clears both stores, sets system_size to 3, empties the output.
`default_nettype none

module cramer_rule_solver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    crs_req_if.sink          request,
    crs_res_if.source        result,
    input  wire logic        system_size_we,
    input  wire logic [1:0]  system_size_wdata
);
    import crs_pkg::*;

    ctl_t ctl;
    st_t  st;
    logic in_ready;
    logic in_fire;
    cmd_t in_command;

    // Items are taken only while the sequencer is idle; a write lands in the
    // store at the accepting edge, a solve starts the determinant walk.
    assign request.ready = in_ready;
    assign in_fire       = request.valid && in_ready;
    assign in_command    = cmd_t'(request.command);

    // Sequencer: walks the Sarrus / cross-product terms one factor per cycle,
    // then hands each quotient to the divider and waits for the output slot.
    crs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (system_size_we),
        .cfg_wdata  (system_size_wdata),
        .in_fire    (in_fire),
        .in_command (in_command),
        .st         (st),
        .ctl        (ctl),
        .in_ready   (in_ready)
    );

    // Datapath: stores, one shared signed multiplier, accumulator, divider,
    // and the result register that decouples the result channel.
    crs_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .st         (st),
        .wr_fire    (in_fire),
        .wr_command (in_command),
        .wr_row     (request.row),
        .wr_column  (request.column),
        .wr_value   (request.value),
        .result     (result)
    );

endmodule

`default_nettype wire

// ===== design/crs_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module crs_divider (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [crs_pkg::SOL_W-1:0]   dividend,
    input  wire logic [crs_pkg::DET_W-1:0]   divisor,
    output logic                             done,
    output logic [crs_pkg::SOL_W-1:0]        quotient
);
    import crs_pkg::*;

    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [SOL_W-1:0]  quo_reg, quo_next;
    logic [DET_W-1:0]  rem_reg, rem_next;
    logic [DET_W-1:0]  den_reg, den_next;
    logic [DET_W:0]    shifted;
    logic [DET_W:0]    diff;
    logic              fits;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[SOL_W-1]};
        diff     = shifted - {1'b0, den_reg};
        fits     = (shifted >= {1'b0, den_reg});
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start)
        begin
            cnt_next = DCNT_W'(SOL_W);
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - DCNT_W'(1);
            quo_next = {quo_reg[SOL_W-2:0], fits};
            rem_next = fits ? diff[DET_W-1:0] : shifted[DET_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = (cnt_reg == DCNT_W'(1));
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== design/crs_ctrl.sv =====
// Solve sequencer: determinant term walk, divide and result emission.
`default_nettype none

module crs_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [1:0]      cfg_wdata,
    input  wire logic            in_fire,
    input  wire crs_pkg::cmd_t   in_command,
    input  wire crs_pkg::st_t    st,
    output crs_pkg::ctl_t        ctl,
    output logic                 in_ready
);
    import crs_pkg::*;

    state_t            state_reg, state_next;
    logic [1:0]        system_size_reg, system_size_next;
    logic              size3_reg, size3_next;
    logic              main_reg, main_next;      // computing the main determinant
    logic              sing_reg, sing_next;
    logic [TERM_W-1:0] term_reg, term_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  rep_col_reg, rep_col_next;
    logic [IDX_W-1:0]  factor;
    logic              term_last;
    logic              var_last;

    assign term_last = (term_reg == (size3_reg ? TERM_W'(5) : TERM_W'(1)));
    assign var_last  = (k_reg == (size3_reg ? IDX_W'(2) : IDX_W'(1)));

    // Next state and counters
    always_comb
    begin
        state_next       = state_reg;
        system_size_next = cfg_we ? cfg_wdata : system_size_reg;
        size3_next       = size3_reg;
        main_next        = main_reg;
        sing_next        = sing_reg;
        term_next        = term_reg;
        k_next           = k_reg;
        rep_col_next     = rep_col_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_command == CMD_SOLVE))
                begin
                    size3_next   = (MAX_SIZE >= 3) && (system_size_reg >= 2'd3);
                    main_next    = 1'b1;
                    sing_next    = 1'b0;
                    term_next    = '0;
                    k_next       = '0;
                    rep_col_next = COL_NONE;
                    state_next   = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                term_next  = '0;
                state_next = ST_LOAD;
            end
            ST_LOAD:  state_next = ST_MUL1;
            ST_MUL1:  state_next = size3_reg ? ST_MUL2 : ST_ACC;
            ST_MUL2:  state_next = ST_ACC;
            ST_ACC:
            begin
                if (term_last)
                begin
                    state_next = main_reg ? ST_SAVE : ST_DIV;
                end
                else
                begin
                    term_next  = term_reg + TERM_W'(1);
                    state_next = ST_LOAD;
                end
            end
            ST_SAVE:
            begin
                main_next    = 1'b0;
                sing_next    = st.acc_zero;
                k_next       = '0;
                rep_col_next = '0;
                state_next   = st.acc_zero ? ST_EMIT : ST_CLEAR;
            end
            ST_DIV:   state_next = ST_WAIT;
            ST_WAIT:  state_next = st.div_done ? ST_EMIT : ST_WAIT;
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    if (var_last)
                    begin
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next       = k_reg + IDX_W'(1);
                        rep_col_next = k_reg + IDX_W'(1);
                        state_next   = sing_reg ? ST_EMIT : ST_CLEAR;
                    end
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        factor = '0;
        case (state_reg)
            ST_MUL1: factor = IDX_W'(1);
            ST_MUL2: factor = IDX_W'(2);
            default: factor = '0;
        endcase
        ctl           = '0;
        ctl.elem_row  = factor;
        ctl.elem_col  = term_col(size3_reg, term_reg, factor);
        ctl.use_rhs   = (ctl.elem_col == rep_col_reg);
        ctl.acc_sub   = term_sub(size3_reg, term_reg);
        ctl.var_idx   = k_reg;
        ctl.last      = var_last;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:  in_ready      = 1'b1;
            ST_CLEAR: ctl.clr_acc   = 1'b1;
            ST_LOAD:  ctl.load      = 1'b1;
            ST_MUL1:  ctl.mul       = 1'b1;
            ST_MUL2:  ctl.mul       = 1'b1;
            ST_ACC:   ctl.acc_en    = 1'b1;
            ST_SAVE:  ctl.save_det  = 1'b1;
            ST_DIV:   ctl.div_start = 1'b1;
            ST_EMIT:  ctl.emit      = st.out_free;
            default:  in_ready      = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            system_size_reg <= 2'd3;
            size3_reg       <= 1'b0;
            main_reg        <= 1'b0;
            sing_reg        <= 1'b0;
            term_reg        <= '0;
            k_reg           <= '0;
            rep_col_reg     <= COL_NONE;
        end
        else
        begin
            state_reg       <= state_next;
            system_size_reg <= system_size_next;
            size3_reg       <= size3_next;
            main_reg        <= main_next;
            sing_reg        <= sing_next;
            term_reg        <= term_next;
            k_reg           <= k_next;
            rep_col_reg     <= rep_col_next;
        end
    end

    a_solve_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_command == CMD_SOLVE)) |=> (state_reg == ST_CLEAR))
        else $error("solve item did not start a determinant pass");

    a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!size3_reg && (state_reg != ST_IDLE)) |-> (term_reg <= TERM_W'(1)))
        else $error("term counter past size-2 range");

    a_rhs_only_in_vars: assert property (@(posedge clk) disable iff (!rst_n)
        (main_reg && (state_reg != ST_IDLE)) |-> !ctl.use_rhs)
        else $error("right-hand side used in main determinant");

    a_emit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && st.div_done) |=> (state_reg == ST_EMIT))
        else $error("divider result not emitted");

endmodule

`default_nettype wire

// ===== design/crs_datapath.sv =====
// Element stores, shared multiplier, accumulator, divider and result register.
`default_nettype none

module crs_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire crs_pkg::ctl_t                      ctl,
    output crs_pkg::st_t                            st,
    input  wire logic                               wr_fire,
    input  wire crs_pkg::cmd_t                      wr_command,
    input  wire logic [crs_pkg::IDX_W-1:0]          wr_row,
    input  wire logic [crs_pkg::IDX_W-1:0]          wr_column,
    input  wire logic signed [crs_pkg::VALUE_BITS-1:0] wr_value,
    crs_res_if.source                               result
);
    import crs_pkg::*;

    logic signed [VALUE_BITS-1:0] coef_reg [MAX_SIZE][MAX_SIZE];
    logic signed [VALUE_BITS-1:0] rhs_reg  [MAX_SIZE];
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic signed [DET_W-1:0]      acc_reg, acc_next;
    logic signed [DET_W-1:0]      det_reg;
    logic                         neg_reg;
    logic signed [VALUE_BITS-1:0] elem;
    logic signed [PROD_W-1:0]     mul_res;
    logic [DET_W-1:0]             mag_num, mag_den;
    logic [SOL_W-1:0]             num_ext, dividend;
    logic [SOL_W-1:0]             quo;
    logic [SOL_W-1:0]             sol;
    logic                         div_done;
    logic                         singular;
    logic                         out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]             out_idx_reg;
    logic [SOL_W-1:0]             out_sol_reg;
    logic signed [DET_W-1:0]      out_det_reg;
    logic                         out_sing_reg;
    logic                         out_last_reg;

    // Element fetch with column replacement
    always_comb
    begin
        if (ctl.use_rhs)
        begin
            elem = rhs_reg[ctl.elem_row[ADDR_W-1:0]];
        end
        else
        begin
            elem = coef_reg[ctl.elem_row[ADDR_W-1:0]][ctl.elem_col[ADDR_W-1:0]];
        end
    end

    assign mul_res = $signed(prod_reg[MULA_W-1:0]) * elem;

    always_comb
    begin
        prod_next = prod_reg;
        if (ctl.load)
        begin
            prod_next = PROD_W'(elem);
        end
        else if (ctl.mul)
        begin
            prod_next = mul_res;
        end
        acc_next = acc_reg;
        if (ctl.clr_acc)
        begin
            acc_next = '0;
        end
        else if (ctl.acc_en)
        begin
            acc_next = ctl.acc_sub ? (acc_reg - DET_W'(prod_reg))
                                   : (acc_reg + DET_W'(prod_reg));
        end
    end

    // Divider operands: magnitudes, numerator scaled to fixed point
    assign mag_num  = acc_reg[DET_W-1] ? DET_W'(-acc_reg) : DET_W'(acc_reg);
    assign mag_den  = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
    assign num_ext  = SOL_W'(mag_num);
    assign dividend = num_ext << FRAC_BITS;

    crs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (dividend),
        .divisor  (mag_den),
        .done     (div_done),
        .quotient (quo)
    );

    // Sign and saturation
    assign singular = (det_reg == '0);
    always_comb
    begin
        if (singular)
        begin
            sol = '0;
        end
        else if (neg_reg)
        begin
            sol = quo[SOL_W-1] ? {1'b1, {(SOL_W-1){1'b0}}} : (~quo + SOL_W'(1));
        end
        else
        begin
            sol = quo[SOL_W-1] ? {1'b0, {(SOL_W-1){1'b1}}} : quo;
        end
    end

    assign out_valid_next = ctl.emit ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_SIZE; r++)
            begin
                rhs_reg[r] <= '0;
                for (int c = 0; c < MAX_SIZE; c++)
                begin
                    coef_reg[r][c] <= '0;
                end
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_fire && (wr_command == CMD_COEF) && (wr_row < IDX_LIMIT)
                && (wr_column < IDX_LIMIT))
            begin
                coef_reg[wr_row[ADDR_W-1:0]][wr_column[ADDR_W-1:0]] <= wr_value;
            end
            if (wr_fire && (wr_command == CMD_RHS) && (wr_row < IDX_LIMIT))
            begin
                rhs_reg[wr_row[ADDR_W-1:0]] <= wr_value;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (ctl.save_det)
        begin
            det_reg <= acc_reg;
        end
        if (ctl.div_start)
        begin
            neg_reg <= acc_reg[DET_W-1] ^ det_reg[DET_W-1];
        end
        if (ctl.emit)
        begin
            out_idx_reg  <= ctl.var_idx;
            out_sol_reg  <= sol;
            out_det_reg  <= det_reg;
            out_sing_reg <= singular;
            out_last_reg <= ctl.last;
        end
    end

    assign st.acc_zero = (acc_reg == '0);
    assign st.div_done = div_done;
    assign st.out_free = !out_valid_reg || result.ready;

    assign result.valid            = out_valid_reg;
    assign result.variable_index   = out_idx_reg;
    assign result.solution         = out_sol_reg;
    assign result.main_determinant = out_det_reg;
    assign result.singular         = out_sing_reg;
    assign result.last             = out_last_reg;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for cramer_rule_solver: directed and random items, built-in predictor.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crs_pkg::*;

    // Worst case: every item a size-3 solve with all three results stalled and a gap
    // before each item. The limit leaves a wide margin.
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 320;      // one full size-3 solve, as a margin
    localparam int PHASE_ITEMS   = 45;       // items per system_size setting
    localparam int MAX_GAP       = 13;

    // system_size values, one per phase; every bit pattern and both extremes
    localparam logic [1:0] SIZE_PLAN [6] = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3};

    // One result item as the block should produce it.
    typedef struct {
        logic [IDX_W-1:0]        variable_index;
        logic signed [SOL_W-1:0] solution;
        logic signed [DET_W-1:0] main_determinant;
        logic                    singular;
        logic                    last;
    } solution_t;

    // Tracks the coefficient and right-hand-side stores and the size register,
    // predicts the unknowns of every solve and checks results in order.
    class solver_scoreboard;
        longint     coef [MAX_SIZE][MAX_SIZE];
        longint     rhs [MAX_SIZE];
        logic [1:0] size_reg;
        solution_t  answers_q[$];
        int         errors;

        function new();
            foreach (coef[r, c])
                coef[r][c] = 0;
            foreach (rhs[r])
                rhs[r] = 0;
            size_reg = 2'd3;
            errors   = 0;
        endfunction

        function void note_size(logic [1:0] v);
            size_reg = v;
        endfunction

        // Determinant of the n x n system, column rep_col swapped for the right-hand side.
        // rep_col >= n gives the main determinant. Size 3 uses the Sarrus diagonals.
        function longint det_with(int n, int rep_col);
            longint a [MAX_SIZE][MAX_SIZE];
            longint plus, minus, p, q;
            int     r, c, i, j;
            for (r = 0; r < n; r++)
                for (c = 0; c < n; c++)
                    a[r][c] = (c == rep_col) ? rhs[r] : coef[r][c];
            if (n == 2)
                return a[0][0] * a[1][1] - a[0][1] * a[1][0];
            plus  = 0;
            minus = 0;
            for (i = 0; i < n; i++)
            begin
                p = 1;
                q = 1;
                for (j = 0; j < n; j++)
                begin
                    p *= a[j][(j + i) % n];
                    q *= a[j][(i + n - j) % n];
                end
                plus  += p;
                minus += q;
            end
            return plus - minus;
        endfunction

        // num/den in fixed point, truncated toward zero, clamped to the 64-bit signed range.
        function logic [SOL_W-1:0] fixed_quotient(longint num, longint den);
            logic [63:0] mag_num, mag_den, q, lim;
            logic        negative;
            mag_num  = (num < 0) ? 64'd0 - 64'(num) : 64'(num);
            mag_den  = (den < 0) ? 64'd0 - 64'(den) : 64'(den);
            q        = (mag_num << FRAC_BITS) / mag_den;
            negative = (num < 0) != (den < 0);
            lim      = 64'd1 << 63;
            if (negative)
                return (q >= lim) ? lim : 64'd0 - q;
            return (q >= lim) ? lim - 64'd1 : q;
        endfunction

        function void note_request(cmd_t cmd, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                   logic signed [VALUE_BITS-1:0] value);
            solution_t e;
            int        n, k;
            longint    d;
            case (cmd)
                CMD_COEF:
                    if (row < MAX_SIZE && col < MAX_SIZE)
                        coef[row][col] = longint'(value);
                CMD_RHS:
                    if (row < MAX_SIZE)
                        rhs[row] = longint'(value);
                CMD_SOLVE:
                begin
                    n = int'(size_reg);
                    if (n < 2)
                        n = 2;
                    if (n > MAX_SIZE)
                        n = MAX_SIZE;
                    d = det_with(n, MAX_SIZE);
                    for (k = 0; k < n; k++)
                    begin
                        e.variable_index   = IDX_W'(k);
                        e.solution         = (d == 0) ? '0 : fixed_quotient(det_with(n, k), d);
                        e.main_determinant = DET_W'(d);
                        e.singular         = (d == 0);
                        e.last             = (k == n - 1);
                        answers_q.insert(answers_q.size(), e);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(solution_t got);
            solution_t want;
            if (answers_q.size() == 0)
            begin
                $error("result for variable %0d with no solve pending", got.variable_index);
                errors++;
                return;
            end
            want = answers_q.pop_front();
            if (got.variable_index !== want.variable_index)
            begin
                $error("variable_index: expected %0d, got %0d",
                       want.variable_index, got.variable_index);
                errors++;
            end
            if (got.solution !== want.solution)
            begin
                $error("solution: expected %0d, got %0d", want.solution, got.solution);
                errors++;
            end
            if (got.main_determinant !== want.main_determinant)
            begin
                $error("main_determinant: expected %0d, got %0d",
                       want.main_determinant, got.main_determinant);
                errors++;
            end
            if (got.singular !== want.singular)
            begin
                $error("singular: expected %0b, got %0b", want.singular, got.singular);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       size_we;
    logic [1:0] size_wdata;
    int         cycle_count = 0;
    int         items_sent = 0;     // items that change a store or start a solve
    bit         req_calm = 1'b0;    // calm: no gaps on the request side for a while
    bit         res_calm = 1'b0;    // calm: no stalls on the result side for a while

    solver_scoreboard sb;

    crs_req_if req_ch ();
    crs_res_if res_ch ();

    cramer_rule_solver uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .request           (req_ch),
        .result            (res_ch),
        .system_size_we    (size_we),
        .system_size_wdata (size_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop if the run hangs, e.g. a result that never comes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Every result item accepted at this edge goes to the scoreboard.
    // Values read right after the edge are the ones that stood at the edge.
    always @(posedge clk)
    begin : result_monitor
        solution_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.variable_index   = res_ch.variable_index;
            got.solution         = res_ch.solution;
            got.main_determinant = res_ch.main_determinant;
            got.singular         = res_ch.singular;
            got.last             = res_ch.last;
            sb.check_result(got);
        end
    end

    // Idle cycles before the next item; now and then the side toggles into a calm
    // stretch with no idling at all.
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 24) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Mostly extremes and small numbers (small ones make singular systems likely),
    // the rest full-range random.
    function automatic int pick_value();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3, 4: return int'($urandom_range(0, 16)) - 8;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Present one request item and hold it until the block takes it.
    // valid stays high afterwards so back-to-back items need no extra assignment.
    task automatic send_item(input cmd_t cmd, input int row, input int col, input int value);
        logic [IDX_W-1:0]             row_f, col_f;
        logic signed [VALUE_BITS-1:0] value_f;
        int                           gap;
        row_f   = IDX_W'(row);
        col_f   = IDX_W'(col);
        value_f = VALUE_BITS'(value);
        gap     = draw_gap(req_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.row     <= row_f;
        req_ch.column  <= col_f;
        req_ch.value   <= value_f;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(cmd, row_f, col_f, value_f);
        if (cmd == CMD_SOLVE || (cmd == CMD_RHS && row_f < MAX_SIZE) ||
            (cmd == CMD_COEF && row_f < MAX_SIZE && col_f < MAX_SIZE))
            items_sent++;
    endtask

    // Anything the fields allow: unused command, out-of-range indexes, stray solves.
    task automatic send_noise();
        send_item(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 3), $urandom_range(0, 3),
                  int'($urandom_range(0, 65535)) - 32768);
    endtask

    // Result side: random stalls between accepted items.
    task automatic accept_results();
        int gap;
        forever
        begin
            gap = draw_gap(res_calm);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
        end
    endtask

    // Drop valid, wait for every predicted result, then let the block go quiet.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.answers_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [1:0] v);
        size_we    <= 1'b1;
        size_wdata <= v;
        @(posedge clk);
        size_we <= 1'b0;
        sb.note_size(v);
    endtask

    // One well-formed round ending in a solve: either a full reload of the n x n system
    // in random order, a few scattered updates, or a copied row that forces a singular
    // matrix. Noise items are mixed in now and then.
    task automatic solve_round(input int n);
        int slots [MAX_SIZE * MAX_SIZE + MAX_SIZE];
        int mode, total, k, idx, tmp, src, dst, c;
        mode = $urandom_range(0, 9);
        if (mode < 6)
        begin
            total = n * n + n;
            for (k = 0; k < total; k++)
                slots[k] = k;
            for (k = total - 1; k > 0; k--)
            begin
                idx      = $urandom_range(0, k);
                tmp      = slots[k];
                slots[k] = slots[idx];
                slots[idx] = tmp;
            end
            for (k = 0; k < total; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_noise();
                idx = slots[k];
                if (idx < n * n)
                    send_item(CMD_COEF, idx / n, idx % n, pick_value());
                else
                    send_item(CMD_RHS, idx - n * n, $urandom_range(0, 3), pick_value());
            end
        end
        else if (mode < 8)
        begin
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 5) == 0)
                    send_noise();
                if ($urandom_range(0, 1) == 1)
                    send_item(CMD_COEF, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                              pick_value());
                else
                    send_item(CMD_RHS, $urandom_range(0, n - 1), $urandom_range(0, 3),
                              pick_value());
            end
        end
        else
        begin
            // overwrite one row with a copy of another: determinant becomes zero
            src = $urandom_range(0, n - 1);
            dst = (src + 1 + $urandom_range(0, n - 2)) % n;
            for (c = 0; c < n; c++)
                send_item(CMD_COEF, dst, c, int'(sb.coef[src][c]));
        end
        send_item(CMD_SOLVE, $urandom_range(0, 3), $urandom_range(0, 3), pick_value());
    endtask

    initial
    begin : stimulus
        int p, eff, target;
        sb = new();
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= CMD_NONE;
        req_ch.row     <= '0;
        req_ch.column  <= '0;
        req_ch.value   <= '0;
        res_ch.ready   <= 1'b0;
        size_we        <= 1'b0;
        size_wdata     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        fork
            accept_results();
        join_none

        // Directed part, size 3 from reset.
        // Solve on freshly cleared stores: all-zero matrix, singular for every unknown.
        send_item(CMD_SOLVE, 0, 0, 0);
        // Extreme coefficients and right-hand sides.
        send_item(CMD_COEF, 0, 0, 32767);
        send_item(CMD_COEF, 1, 1, -32768);
        send_item(CMD_COEF, 2, 2, 1);
        send_item(CMD_COEF, 0, 2, -1);
        send_item(CMD_COEF, 2, 0, -32768);
        send_item(CMD_RHS, 0, 0, -32768);
        send_item(CMD_RHS, 1, 3, 32767);
        send_item(CMD_RHS, 2, 1, -1);
        // Out-of-range indexes and the unused command must leave the stores alone.
        send_item(CMD_COEF, 3, 1, 1234);
        send_item(CMD_COEF, 1, 3, -1234);
        send_item(CMD_RHS, 3, 0, 999);
        send_item(CMD_NONE, 3, 3, -1);
        send_item(CMD_SOLVE, 3, 3, -1);
        // Row 1 made equal to row 0: singular with non-zero stores.
        send_item(CMD_COEF, 1, 0, 32767);
        send_item(CMD_COEF, 1, 1, 0);
        send_item(CMD_COEF, 1, 2, -1);
        send_item(CMD_SOLVE, 0, 0, 0);
        settle();

        // Random part, one phase per size setting; size 0 and 1 behave as 2.
        for (p = 0; p < 6; p++)
        begin
            write_size(SIZE_PLAN[p]);
            eff    = (SIZE_PLAN[p] < 2'd2) ? 2 : int'(SIZE_PLAN[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                solve_round(eff);
            settle();
        end

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== cramer_rule_solver.f =====
design/crs_pkg.sv
design/crs_if.sv
design/crs_divider.sv
design/crs_ctrl.sv
design/crs_datapath.sv
design/cramer_rule_solver.sv
sim/tb.sv
